### rtl/ghe_pkg.sv
// shared types and constants for the group histogram equalizer
package ghe_pkg;
	localparam int DATA_W = 28;
	localparam int BW_W = 25;
	localparam int CNT_W = 16;
	localparam int LEVEL_W = 25;
	localparam int MODE_W = 2;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int FRAC_W = 24;
	localparam int DIV_W = CNT_W + FRAC_W;

	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MAP = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_SMALL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GROUP = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SWEEP, ST_BIN_DIV, ST_ADD_RD, ST_ADD_WR,
		ST_PFX_RD, ST_PFX_WR, ST_MAP_RD, ST_MAP_DIV, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [BW_W-1:0] divisor;
	} div_req_t;
endpackage

### rtl/ghe_if.sv
// valid/ready channel interfaces for the equalizer
interface ghe_in_if;
	logic valid;
	logic ready;
	logic [ghe_pkg::MODE_W-1:0] mode;
	logic signed [ghe_pkg::DATA_W-1:0] sample_value;
	modport source(output valid, mode, sample_value, input ready);
	modport sink(input valid, mode, sample_value, output ready);
endinterface

interface ghe_out_if;
	logic valid;
	logic ready;
	logic [ghe_pkg::LEVEL_W-1:0] level;
	logic [ghe_pkg::STATUS_W-1:0] status;
	modport source(output valid, level, status, input ready);
	modport sink(input valid, level, status, output ready);
endinterface

### rtl/ghe_divider.sv
// restoring divider, one quotient bit per cycle
module ghe_divider (
	input logic clk,
	input logic arst_n,
	input ghe_pkg::div_req_t req,
	output logic busy,
	output logic [ghe_pkg::DIV_W-1:0] quotient
);
	localparam int QW = ghe_pkg::DIV_W;
	localparam int RW = ghe_pkg::BW_W + 1;

	logic [QW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic [ghe_pkg::BW_W-1:0] dvs_q;
	logic [$clog2(QW+1)-1:0] cnt_q;
	logic [RW-1:0] trial;
	logic [RW:0] diff;

	assign trial = {rem_q[RW-2:0], quo_q[QW-1]};
	assign diff = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= ($clog2(QW+1))'(QW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			if (!diff[RW]) begin
				rem_q <= diff[RW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quotient = quo_q;
endmodule

### rtl/group_histogram_equalizer.sv
// group histogram equalizer top level
// Usage: configuration is written through cfg_we / cfg_index / cfg_data while idle
// (range_low, bin_width, min_group). Items arrive on in_ch (mode, sample_value) and
// a map item returns one result on out_ch (level, status); clear, add and the
// unused mode give none.
// Bin counts live in one synchronous single-port memory of BINS entries.
// Work done between one input transaction and the next possible one:
// clear zeroes all BINS entries in a sweep (one memory entry zeroed per cycle).
// Add: a bit-serial divider finds the bin, then a read and a write of the bin.
// Map runs a bin division, a read, and a second division for the level (skipped
// when no sample of the group was in range); the next transaction is taken once
// the result has been delivered and the block is back in idle.
// The first map after adds first runs a prefix sweep over all BINS entries.
// An add after a map, until the next clear, and the unused mode have no effect.
// The divider is the limiting unit for add and map; the memory port limits sweeps.
// After reset the block clears all BINS entries in a sweep before taking items.
// A result waits in the output register while the receiver stalls; no new item
// is taken until it has been delivered.
module group_histogram_equalizer #(
	parameter int BINS = 10000,
	parameter int MAX_GROUP = 65535
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [ghe_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [ghe_pkg::DATA_W-1:0] cfg_data,
	ghe_in_if.sink in_ch,
	ghe_out_if.source out_ch
);
	localparam int AW = $clog2(BINS);
	localparam int CW = ghe_pkg::CNT_W;
	localparam int DW = ghe_pkg::DATA_W;
	localparam logic [CW-1:0] CMAX = '1;
	localparam logic [CW-1:0] GMAX = CW'(MAX_GROUP);
	localparam logic [AW:0] LAST = (AW+1)'(BINS - 1);

	logic signed [DW-1:0] range_low_q;
	logic [ghe_pkg::BW_W-1:0] bin_width_q;
	logic [CW-1:0] min_group_q;
	logic [CW-1:0] group_size_q, total_q;
	logic prefix_q;
	ghe_pkg::state_t state_q, state_d;

	logic [CW-1:0] mem [BINS];
	logic [CW-1:0] rd_data;
	logic mem_we, mem_re;
	logic [AW-1:0] mem_addr;
	logic [CW-1:0] mem_wdata;

	logic [ghe_pkg::MODE_W-1:0] mode_q;
	logic signed [DW-1:0] sample_q;
	logic [AW:0] ptr_q;
	logic [CW:0] run_q;
	logic range_bad_q;
	logic [AW-1:0] bin_q;
	logic [CW-1:0] pfx_q;
	logic [ghe_pkg::LEVEL_W-1:0] level_q;
	logic [ghe_pkg::STATUS_W-1:0] status_q;
	logic out_valid_q;

	ghe_pkg::div_req_t dreq;
	logic dbusy;
	logic [ghe_pkg::DIV_W-1:0] dquo;
	logic signed [DW:0] delta;
	logic [ghe_pkg::BW_W-1:0] wdiv;
	logic [CW:0] run_sum;

	ghe_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .quotient(dquo));

	assign delta = $signed({sample_q[DW-1], sample_q}) -
		$signed({range_low_q[DW-1], range_low_q});
	assign wdiv = (bin_width_q == '0) ? ghe_pkg::BW_W'(1) : bin_width_q;
	assign run_sum = run_q + {1'b0, rd_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q <= DW'(-1678);
			bin_width_q <= ghe_pkg::BW_W'(1711);
			min_group_q <= CW'(10);
		end else if (cfg_we) begin
			case (cfg_index)
				ghe_pkg::REG_RANGE_LOW: range_low_q <= cfg_data;
				ghe_pkg::REG_BIN_WIDTH: bin_width_q <= cfg_data[ghe_pkg::BW_W-1:0];
				ghe_pkg::REG_MIN_GROUP: min_group_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (mem_re) rd_data <= mem[mem_addr];
	end

	always_comb begin
		state_d = state_q;
		in_ch.ready = 1'b0;
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_addr = ptr_q[AW-1:0];
		mem_wdata = '0;
		dreq.start = 1'b0;
		dreq.dividend = ghe_pkg::DIV_W'(delta);
		dreq.divisor = wdiv;
		case (state_q)
			ghe_pkg::ST_SWEEP: begin
				mem_we = 1'b1;
				if (ptr_q == LAST) state_d = ghe_pkg::ST_IDLE;
			end
			ghe_pkg::ST_IDLE: begin
				in_ch.ready = !out_valid_q;
				if (in_ch.valid && !out_valid_q) begin
					case (in_ch.mode)
						ghe_pkg::MODE_CLEAR: state_d = ghe_pkg::ST_SWEEP;
						ghe_pkg::MODE_ADD:
							if (!prefix_q) state_d = ghe_pkg::ST_BIN_DIV;
						ghe_pkg::MODE_MAP: state_d = prefix_q ? ghe_pkg::ST_BIN_DIV
							: ghe_pkg::ST_PFX_RD;
						default: ;
					endcase
				end
			end
			ghe_pkg::ST_PFX_RD: begin
				mem_re = 1'b1;
				state_d = ghe_pkg::ST_PFX_WR;
			end
			ghe_pkg::ST_PFX_WR: begin
				mem_we = 1'b1;
				mem_wdata = run_q[CW-1:0];
				state_d = (ptr_q == LAST) ? ghe_pkg::ST_BIN_DIV : ghe_pkg::ST_PFX_RD;
			end
			ghe_pkg::ST_BIN_DIV: begin
				if (!dbusy && !range_bad_q) begin
					dreq.start = 1'b1;
					state_d = ghe_pkg::ST_BIN_DIV;
				end
				if (dbusy == 1'b0 && range_bad_q) begin
					state_d = (mode_q == ghe_pkg::MODE_ADD) ? ghe_pkg::ST_ADD_RD
						: ghe_pkg::ST_MAP_RD;
				end
			end
			ghe_pkg::ST_ADD_RD: begin
				mem_addr = bin_q;
				mem_re = 1'b1;
				state_d = ghe_pkg::ST_ADD_WR;
			end
			ghe_pkg::ST_ADD_WR: begin
				mem_addr = bin_q;
				mem_we = !range_bad_q;
				mem_wdata = (rd_data == CMAX) ? rd_data : rd_data + 1'b1;
				state_d = ghe_pkg::ST_IDLE;
			end
			ghe_pkg::ST_MAP_RD: begin
				mem_addr = bin_q;
				mem_re = 1'b1;
				state_d = ghe_pkg::ST_MAP_DIV;
			end
			ghe_pkg::ST_MAP_DIV: begin
				if (!dbusy && !range_bad_q) begin
					dreq.start = 1'b1;
					dreq.dividend = ghe_pkg::DIV_W'(rd_data) << ghe_pkg::FRAC_W;
					dreq.divisor = ghe_pkg::BW_W'(total_q);
				end
				if (!dbusy && range_bad_q) state_d = ghe_pkg::ST_OUT;
			end
			ghe_pkg::ST_OUT: state_d = ghe_pkg::ST_IDLE;
			default: state_d = ghe_pkg::ST_IDLE;
		endcase
	end

	// range_bad_q doubles as a phase flag: set when the divider launched, cleared after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ghe_pkg::ST_SWEEP;
			ptr_q <= '0;
			group_size_q <= '0;
			total_q <= '0;
			prefix_q <= 1'b0;
			out_valid_q <= 1'b0;
			range_bad_q <= 1'b0;
			run_q <= '0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			if (dreq.start) range_bad_q <= 1'b1;
			case (state_q)
				ghe_pkg::ST_SWEEP: ptr_q <= ptr_q + 1'b1;
				ghe_pkg::ST_IDLE: begin
					ptr_q <= '0;
					run_q <= '0;
					range_bad_q <= 1'b0;
					if (in_ch.valid && in_ch.ready && in_ch.mode == ghe_pkg::MODE_CLEAR) begin
						group_size_q <= '0;
						total_q <= '0;
						prefix_q <= 1'b0;
					end
				end
				ghe_pkg::ST_PFX_WR: begin
					ptr_q <= ptr_q + 1'b1;
					run_q <= (run_sum > (CW+1)'(CMAX)) ? {1'b0, CMAX} : run_sum;
					if (ptr_q == LAST) prefix_q <= 1'b1;
				end
				ghe_pkg::ST_BIN_DIV: if (!dbusy && range_bad_q) begin
					range_bad_q <= 1'b0;
					if (delta < 0 || dquo >= ghe_pkg::DIV_W'(BINS)) begin
						bin_q <= '0;
						pfx_q <= CW'(1);
					end else begin
						bin_q <= dquo[AW-1:0];
						pfx_q <= '0;
					end
				end
				ghe_pkg::ST_ADD_RD: begin
					range_bad_q <= pfx_q[0];
					if (group_size_q < GMAX) group_size_q <= group_size_q + 1'b1;
					if (!pfx_q[0] && total_q != CMAX) total_q <= total_q + 1'b1;
				end
				ghe_pkg::ST_ADD_WR: range_bad_q <= 1'b0;
				ghe_pkg::ST_MAP_RD: range_bad_q <= (total_q == '0);
				ghe_pkg::ST_MAP_DIV: if (!dbusy && range_bad_q) begin
					out_valid_q <= 1'b1;
					if (group_size_q < min_group_q) begin
						status_q <= ghe_pkg::ST_SMALL;
						level_q <= '0;
					end else if (pfx_q[0]) begin
						status_q <= ghe_pkg::ST_RANGE;
						level_q <= '0;
					end else begin
						status_q <= ghe_pkg::ST_OK;
						level_q <= ((total_q == '0) ? ghe_pkg::LEVEL_W'(0)
							: dquo[ghe_pkg::LEVEL_W-1:0]) + (bin_width_q >> 1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			mode_q <= in_ch.mode;
			sample_q <= in_ch.sample_value;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.level = level_q;
	assign out_ch.status = status_q;
endmodule
